>>> rtl/pmc_pkg.sv
`timescale 1ns / 1ps

package pmc_pkg;

  // one framed mouse packet: status, X delta, Y delta
  typedef struct packed {
    logic [7:0] status;
    logic [7:0] x_delta;
    logic [7:0] y_delta;
  } pkt_t;

  typedef enum logic [1:0] {
    FR_SYNC   = 2'd0,
    FR_XDELTA = 2'd1,
    FR_YDELTA = 2'd2
  } frame_state_t;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [7:0]  SYNC_MASK    = 8'h08;
  localparam logic [7:0]  LEFT_MASK    = 8'h01;
  localparam logic [7:0]  GAIN_RESET   = 8'd22;
  localparam logic [12:0] WIDTH_RESET  = 13'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd768;
  localparam int          POS_RESET    = 50;

  // x / 10 == (x * 52429) >> 19, exact for x below 43690
  localparam logic [15:0] RECIP10      = 16'd52429;
  localparam int          RECIP_SHIFT  = 19;

endpackage

>>> rtl/ps2_mouse_packet_cursor.sv
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with cursor tracking.
// Input channel: raw mouse bytes, one per transaction (in_push / in_full).
// A byte is taken whenever in_full is low; with enable clear it is dropped.
// Bytes are framed into 3-byte packets; a candidate first byte without
// bit 3 set is discarded so the framer resyncs on its own.
// Result channel (out_empty / out_pop): one transaction per packet with the
// clamped cursor position, the status byte and a left-press edge flag.
// A packet's result passes the packet queue, the multiply stage and the
// divide-by-ten stage with clamp/write into the result queue.
// Throughput: one byte per cycle while in_full is low; a packet queue of 4 sits
// between framer and arithmetic, and a 4-entry result queue follows it.
// When the receiver stops popping, the result queue fills, the arithmetic
// stops pulling packets, the packet queue fills and in_full rises.
// cfg_ready is always high; write registers only while the block is idle.
// Synchronous reset restores enable = 0, gain 2.2, a 1024 x 768 screen,
// cursor at (50, 50), and empties both queues.
module ps2_mouse_packet_cursor #(
  parameter int COORD_BITS    = 12,
  parameter int CURSOR_MARGIN = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_data_byte,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [COORD_BITS-1:0] out_cursor_x,
  output logic [COORD_BITS-1:0] out_cursor_y,
  output logic [7:0]            out_status_byte,
  output logic                  out_left_click,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [12:0]           cfg_data
);

  import pmc_pkg::*;

  localparam int PKT_DEPTH = 4;
  localparam int PKT_CNT_W = $clog2(PKT_DEPTH + 1);

  logic        enable_r;
  logic [7:0]  gain_r;
  logic [12:0] width_r, height_r;

  logic        byte_valid;
  logic        pkt_push, pkt_full, pkt_pop, pkt_empty;
  logic [PKT_CNT_W-1:0] pkt_count;
  pkt_t        pkt_wr, pkt_rd;

  assign cfg_ready  = 1'b1;
  assign in_full    = pkt_full;
  assign byte_valid = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      gain_r   <= GAIN_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_GAIN:   gain_r   <= cfg_data[7:0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    enable_r <= enable_r;
      endcase
    end
  end

  pmc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .data_byte  (in_data_byte),
    .enable     (enable_r),
    .pkt_push   (pkt_push),
    .pkt_data   (pkt_wr)
  );

  pmc_fifo #(
    .WIDTH ($bits(pkt_t)),
    .DEPTH (PKT_DEPTH)
  ) u_pkt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pkt_push),
    .wdata (pkt_wr),
    .full  (pkt_full),
    .pop   (pkt_pop),
    .rdata (pkt_rd),
    .empty (pkt_empty),
    .count (pkt_count)
  );

  pmc_back #(
    .COORD_BITS    (COORD_BITS),
    .CURSOR_MARGIN (CURSOR_MARGIN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pkt_empty       (pkt_empty),
    .pkt_data        (pkt_rd),
    .pkt_pop         (pkt_pop),
    .gain_tenths     (gain_r),
    .screen_width    (width_r),
    .screen_height   (height_r),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_cursor_x    (out_cursor_x),
    .out_cursor_y    (out_cursor_y),
    .out_status_byte (out_status_byte),
    .out_left_click  (out_left_click)
  );

  // a finished packet is never lost to a full packet queue
  a_pkt_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pkt_push && pkt_full))
    else $error("packet pushed into full queue");

  // the arithmetic only pulls a packet that is there
  a_pkt_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pkt_pop && pkt_empty))
    else $error("packet popped from empty queue");

  // packet queue occupancy stays within its depth
  a_pkt_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_count <= PKT_CNT_W'(PKT_DEPTH))
    else $error("packet queue count beyond depth");

  // reset leaves no stale result behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible right after reset");

endmodule

>>> rtl/pmc_fifo.sv
`timescale 1ns / 1ps

module pmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers wrap naturally: DEPTH is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/pmc_front.sv
`timescale 1ns / 1ps

module pmc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    data_byte,
  input  logic          enable,
  output logic          pkt_push,
  output pmc_pkg::pkt_t pkt_data
);

  import pmc_pkg::*;

  frame_state_t state_r, state_nxt;
  logic [7:0]   status_r, status_nxt;
  logic [7:0]   xdelta_r, xdelta_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FR_SYNC;
      status_r <= '0;
      xdelta_r <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      xdelta_r <= xdelta_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    xdelta_nxt = xdelta_r;
    pkt_push   = 1'b0;
    pkt_data   = '{status: status_r, x_delta: xdelta_r, y_delta: data_byte};
    if (byte_valid && enable) begin
      unique case (state_r)
        FR_SYNC: begin
          // resync: a first byte must carry the always-one bit
          if ((data_byte & SYNC_MASK) != '0) begin
            status_nxt = data_byte;
            state_nxt  = FR_XDELTA;
          end
        end
        FR_XDELTA: begin
          xdelta_nxt = data_byte;
          state_nxt  = FR_YDELTA;
        end
        default: begin
          pkt_push  = 1'b1;
          state_nxt = FR_SYNC;
        end
      endcase
    end
  end

endmodule

>>> rtl/pmc_back.sv
`timescale 1ns / 1ps

module pmc_back #(
  parameter int COORD_BITS    = 12,
  parameter int CURSOR_MARGIN = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pkt_empty,
  input  pmc_pkg::pkt_t         pkt_data,
  output logic                  pkt_pop,
  input  logic [7:0]            gain_tenths,
  input  logic [12:0]           screen_width,
  input  logic [12:0]           screen_height,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [COORD_BITS-1:0] out_cursor_x,
  output logic [COORD_BITS-1:0] out_cursor_y,
  output logic [7:0]            out_status_byte,
  output logic                  out_left_click
);

  import pmc_pkg::*;

  localparam int OUT_DEPTH = 4;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int ITEM_W    = 2 * COORD_BITS + 9;
  localparam int SW        = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
  localparam int LW        = SW - 1;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // stage 1: products
  logic               v1_r;
  logic signed [16:0] prodx1_r, prody1_r;
  logic [7:0]         status1_r;
  // stage 2: quotient magnitudes and signs
  logic               v2_r;
  logic [11:0]        qx2_r, qy2_r;
  logic               sx2_r, sy2_r;
  logic [7:0]         status2_r;
  // cursor state
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r;
  logic                  prev_left_r;

  logic [CNT_W-1:0]   out_count;
  logic [CNT_W:0]     in_flight;
  logic               out_full;
  logic signed [16:0] prodx, prody;
  logic [14:0]        absx, absy;
  logic [30:0]        mulx, muly;
  logic [LW-1:0]      lim_x, lim_y;
  logic signed [SW-1:0] dx, dy, nx, ny;
  logic [COORD_BITS-1:0] new_x, new_y;
  logic                  left, click;
  logic [ITEM_W-1:0]     wr_item, rd_item;

  // pull a packet only when every one in flight has a slot waiting
  assign in_flight = (CNT_W+1)'(out_count) + (CNT_W+1)'(v1_r) + (CNT_W+1)'(v2_r);
  assign pkt_pop   = !pkt_empty && (in_flight < (CNT_W+1)'(OUT_DEPTH));

  assign prodx = $signed({{9{pkt_data.x_delta[7]}}, pkt_data.x_delta})
               * $signed({9'b0, gain_tenths});
  assign prody = $signed({{9{pkt_data.y_delta[7]}}, pkt_data.y_delta})
               * $signed({9'b0, gain_tenths});

  assign absx = prodx1_r[16] ? 15'(-prodx1_r) : 15'(prodx1_r);
  assign absy = prody1_r[16] ? 15'(-prody1_r) : 15'(prody1_r);
  assign mulx = {16'b0, absx} * {15'b0, RECIP10};
  assign muly = {16'b0, absy} * {15'b0, RECIP10};

  function automatic logic [LW-1:0] limit_of(input logic [12:0] size);
    logic [LW-1:0] s;
    logic [LW-1:0] l;
    s = LW'(size);
    if (s < LW'(CURSOR_MARGIN)) l = '0;
    else                        l = s - LW'(CURSOR_MARGIN);
    if (l > LW'(COORD_MAX))     l = LW'(COORD_MAX);
    return l;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                  input logic [LW-1:0] lim);
    logic [COORD_BITS-1:0] r;
    if (v < 0)                          r = '0;
    else if (v >= $signed({1'b0, lim})) r = COORD_BITS'(lim);
    else                                r = COORD_BITS'(v);
    return r;
  endfunction

  assign lim_x = limit_of(screen_width);
  assign lim_y = limit_of(screen_height);

  always_comb begin
    dx    = sx2_r ? -$signed(SW'(qx2_r)) : $signed(SW'(qx2_r));
    dy    = sy2_r ? -$signed(SW'(qy2_r)) : $signed(SW'(qy2_r));
    nx    = $signed(SW'(pos_x_r)) + dx;
    ny    = $signed(SW'(pos_y_r)) - dy;
    new_x = clamp(nx, lim_x);
    new_y = clamp(ny, lim_y);
    left  = (status2_r & LEFT_MASK) != '0;
    click = left && !prev_left_r;
  end

  assign wr_item = {new_x, new_y, status2_r, click};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pos_x_r     <= COORD_BITS'(POS_RESET);
      pos_y_r     <= COORD_BITS'(POS_RESET);
      prev_left_r <= 1'b0;
    end else begin
      v1_r <= pkt_pop;
      v2_r <= v1_r;
      if (v2_r) begin
        pos_x_r     <= new_x;
        pos_y_r     <= new_y;
        prev_left_r <= left;
      end
    end
  end

  always_ff @(posedge clk) begin
    prodx1_r  <= prodx;
    prody1_r  <= prody;
    status1_r <= pkt_data.status;
    qx2_r     <= mulx[RECIP_SHIFT +: 12];
    qy2_r     <= muly[RECIP_SHIFT +: 12];
    sx2_r     <= prodx1_r[16];
    sy2_r     <= prody1_r[16];
    status2_r <= status1_r;
  end

  pmc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v2_r),
    .wdata (wr_item),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (rd_item),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_cursor_x    = rd_item[ITEM_W-1 -: COORD_BITS];
  assign out_cursor_y    = rd_item[COORD_BITS+8 : 9];
  assign out_status_byte = rd_item[8:1];
  assign out_left_click  = rd_item[0];

  always_ff @(posedge clk) begin
    if (rst_n && v2_r && out_full) begin
      $error("result queue written while full");
    end
  end

endmodule
